// ===== src/rmpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rmpc_pkg - rumble motor pattern controller package
// Field widths, command codes, effect kinds, tuning constants and the
// control/status bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package rmpc_pkg;

  // item field widths
  localparam int MODE_W  = 3;
  localparam int DUR_W   = 15;
  localparam int STR_W   = 8;
  localparam int DEC_W   = 8;
  localparam int LVL_W   = 3;
  localparam int FRAME_W = 32;

  // internal widths
  localparam int KIND_W = 2;
  localparam int ACC_W  = 16;
  localparam int LEAD_W = 3;
  localparam int HOLD_W = 3;
  localparam int PER_W  = 3;
  localparam int SQ_W   = 2 * STR_W;
  localparam int CUBE_W = 3 * STR_W;

  // frame remainder is taken one byte per cycle, MSB first
  localparam int DIGIT_W    = 8;
  localparam int NUM_DIGITS = FRAME_W / DIGIT_W;
  localparam int DCNT_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  localparam int QUEUE_DEPTH_DEF = 3;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_ENABLE_IDX = '0;
  localparam logic ENABLE_RST = 1'b1;

  // pattern constants
  localparam int LEAD_TICKS     = 4;
  localparam int ACC_THRESH     = 'h100;
  localparam int CUBE_SHIFT     = 9;
  localparam int CUBE_BIAS      = 4;
  localparam int SOLID_THRESH   = 70;
  localparam int HOLD_ON_MIN    = 5;
  localparam int HOLD_PULSE_MIN = 2;
  localparam int HOLD_RESTART   = 7;
  localparam int HOLD_FLOOR     = 4;
  localparam int PERIOD_RESTART = 7;
  localparam int BUZZ_HOLD      = 4;
  localparam int BUZZ_PERIOD    = 4;
  localparam int LEVEL_MAX      = 4;
  localparam int PERIOD_BASE    = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK       = 3'd0,
    MODE_QUEUE      = 3'd1,
    MODE_SET_DECAY  = 3'd2,
    MODE_RESET_HOLD = 3'd3,
    MODE_HOLD_LEVEL = 3'd4,
    MODE_BUZZ       = 3'd5,
    MODE_CANCEL     = 3'd6,
    MODE_STATUS     = 3'd7
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE    = 2'd0,
    KIND_SOLID   = 2'd1,
    KIND_DENSITY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic in_valid;
    logic in_tick;
    logic calc_busy;
    logic out_free;
  } rmpc_status_t;

  typedef struct packed {
    logic in_ready;
    logic commit;
  } rmpc_cmd_t;

endpackage

// ===== src/rmpc_if.sv =====
// ----------------------------------------------------------------------------
// rmpc_if - item channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface rmpc_in_if import rmpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [DUR_W-1:0]   duration;
  logic [STR_W-1:0]   strength;
  logic [DEC_W-1:0]   decay;
  logic [LVL_W-1:0]   level;
  logic [FRAME_W-1:0] frame_count;

  modport source (
    output valid, mode, duration, strength, decay, level, frame_count,
    input  ready
  );
  modport sink (
    input  valid, mode, duration, strength, decay, level, frame_count,
    output ready
  );
endinterface

interface rmpc_out_if;
  logic valid;
  logic ready;
  logic motor_on;
  logic motor_changed;
  logic idle;

  modport source (
    output valid, motor_on, motor_changed, idle,
    input  ready
  );
  modport sink (
    input  valid, motor_on, motor_changed, idle,
    output ready
  );
endinterface

// ===== src/rmpc_mod.sv =====
// ----------------------------------------------------------------------------
// rmpc_mod - frame counter remainder unit
// Reduces the frame counter modulo the pulse period, one byte per cycle.
// ----------------------------------------------------------------------------
module rmpc_mod import rmpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [FRAME_W-1:0] frame_i,
  input  logic [PER_W-1:0]   period_i,
  output logic               busy_o,
  output logic [PER_W-1:0]   rem_o
);

  localparam int XW = PER_W + DIGIT_W;

  logic [FRAME_W-1:0] shift_q, shift_d;
  logic [PER_W-1:0]   rem_q, rem_d;
  logic [DCNT_W-1:0]  cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [XW-1:0]      x;
  logic [XW-1:0]      sub;

  // restoring reduction of {rem, next byte}; rem < period keeps it in range
  always_comb begin
    x = {rem_q, shift_q[FRAME_W-1 -: DIGIT_W]};
    for (int k = DIGIT_W - 1; k >= 0; k--) begin
      sub = XW'(period_i) << k;
      if (x >= sub) begin
        x = x - sub;
      end
    end
  end

  always_comb begin
    shift_d = shift_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      shift_d = frame_i;
      rem_d   = '0;
      cnt_d   = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      shift_d = shift_q << DIGIT_W;
      rem_d   = x[PER_W-1:0];
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(NUM_DIGITS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && cnt_q == '0)
    else $error("remainder unit did not start");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i && cnt_q == DCNT_W'(NUM_DIGITS - 1) && period_i != '0
      && $stable(period_i) |=> rem_q < period_i)
    else $error("remainder not below period");

endmodule

// ===== src/rmpc_cube.sv =====
// ----------------------------------------------------------------------------
// rmpc_cube - density step unit
// Two-stage strength cube; gives cube / 512 + 4 for the density accumulator.
// ----------------------------------------------------------------------------
module rmpc_cube import rmpc_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [STR_W-1:0] s_i,
  output logic [ACC_W-1:0] add_o
);

  logic [SQ_W-1:0]   sq_q;
  logic [STR_W-1:0]  s_q;
  logic [CUBE_W-1:0] cube_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q   <= SQ_W'(s_i) * SQ_W'(s_i);
      s_q    <= s_i;
      cube_q <= CUBE_W'(sq_q) * CUBE_W'(s_q);
    end
  end

  assign add_o = ACC_W'(cube_q[CUBE_W-1:CUBE_SHIFT]) + ACC_W'(CUBE_BIAS);

endmodule

// ===== src/rmpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmpc_ctrl - sequencer
// Takes one item at a time, waits for the arithmetic of a tick, then
// commits the new state once the result register is free.
// ----------------------------------------------------------------------------
module rmpc_ctrl import rmpc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rmpc_status_t st_i,
  output rmpc_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (st_i.in_valid) begin
          state_d = st_i.in_tick ? ST_CALC : ST_COMMIT;
        end
      end
      ST_CALC: begin
        if (!st_i.calc_busy) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (st_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:   cmd_o.in_ready = 1'b1;
      ST_CALC:   cmd_o = '0;
      ST_COMMIT: cmd_o.commit = st_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/rmpc_dp.sv =====
// ----------------------------------------------------------------------------
// rmpc_dp - pattern datapath
// Effect queue, active effect, phase counters, density accumulator and
// result register; applies one item to the state on commit.
// ----------------------------------------------------------------------------
module rmpc_dp import rmpc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          enable_i,
  rmpc_in_if.sink       in_i,
  rmpc_out_if.source    out_o,
  input  rmpc_cmd_t     cmd_i,
  output rmpc_status_t  st_o
);

  localparam int LAST = QUEUE_DEPTH - 1;

  // queue
  kind_e            kind_q [QUEUE_DEPTH];
  kind_e            kind_d [QUEUE_DEPTH];
  logic [STR_W-1:0] sstr_q [QUEUE_DEPTH];
  logic [STR_W-1:0] sstr_d [QUEUE_DEPTH];
  logic [DUR_W-1:0] sdur_q [QUEUE_DEPTH];
  logic [DUR_W-1:0] sdur_d [QUEUE_DEPTH];
  logic [DEC_W-1:0] sdec_q [QUEUE_DEPTH];
  logic [DEC_W-1:0] sdec_d [QUEUE_DEPTH];

  // active effect and counters
  kind_e             akind_q, akind_d;
  logic [STR_W-1:0]  astr_q, astr_d;
  logic [DEC_W-1:0]  adec_q, adec_d;
  logic [DUR_W-1:0]  rem_q, rem_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [LEAD_W-1:0] lead_q, lead_d;
  logic [HOLD_W-1:0] hold_q, hold_d;
  logic [PER_W-1:0]  per_q, per_d;
  logic              motor_q, motor_d;

  // latched item
  mode_e             m_q;
  logic [DUR_W-1:0]  dur_q;
  logic [STR_W-1:0]  str_q;
  logic [DEC_W-1:0]  dec_q;
  logic [LVL_W-1:0]  lvl_q;

  // result register
  logic out_valid_q;
  logic changed_q, changed_d;
  logic idle_q, idle_d;

  logic              accept;
  logic              calc_busy;
  logic [PER_W-1:0]  frame_rem;
  logic [ACC_W-1:0]  cube_add;
  logic [STR_W-1:0]  str_decayed;
  logic [HOLD_W-1:0] hold_rst;
  logic              on;
  logic              any_slot;
  logic [DUR_W:0]    busy_sum;

  assign accept = in_i.valid & cmd_i.in_ready;
  assign in_i.ready = cmd_i.in_ready;

  assign st_o.in_valid  = in_i.valid;
  assign st_o.in_tick   = (in_i.mode == MODE_TICK);
  assign st_o.calc_busy = calc_busy;
  assign st_o.out_free  = !out_valid_q || out_o.ready;

  assign str_decayed = (astr_q > adec_q) ? (astr_q - adec_q) : '0;

  // only ticks use the remainder, so the period holds still while it runs
  rmpc_mod u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept && (in_i.mode == MODE_TICK)),
    .frame_i  (in_i.frame_count),
    .period_i (per_q),
    .busy_o   (calc_busy),
    .rem_o    (frame_rem)
  );

  // strength and decay only change on commit, so the cube is ready in time
  rmpc_cube u_cube (
    .clk_i (clk_i),
    .en_i  (calc_busy),
    .s_i   (str_decayed),
    .add_o (cube_add)
  );

  // hold restart: zero becomes the full hold, then a floor is applied
  always_comb begin
    hold_rst = (hold_q == '0) ? HOLD_W'(HOLD_RESTART) : hold_q;
    if (hold_rst < HOLD_W'(HOLD_FLOOR)) begin
      hold_rst = HOLD_W'(HOLD_FLOOR);
    end
  end

  always_comb begin
    kind_d  = kind_q;
    sstr_d  = sstr_q;
    sdur_d  = sdur_q;
    sdec_d  = sdec_q;
    akind_d = akind_q;
    astr_d  = astr_q;
    adec_d  = adec_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    lead_d  = lead_q;
    hold_d  = hold_q;
    per_d   = per_q;
    motor_d = motor_q;
    on      = 1'b0;

    case (m_q)
      MODE_TICK: begin
        if (kind_q[0] != KIND_NONE) begin
          acc_d   = '0;
          lead_d  = LEAD_W'(LEAD_TICKS);
          akind_d = kind_q[0];
          rem_d   = sdur_q[0];
          astr_d  = sstr_q[0];
          adec_d  = sdec_q[0];
        end
        for (int i = 0; i < LAST; i++) begin
          kind_d[i] = kind_q[i+1];
          sstr_d[i] = sstr_q[i+1];
          sdur_d[i] = sdur_q[i+1];
          sdec_d[i] = sdec_q[i+1];
        end
        kind_d[LAST] = KIND_NONE;

        // a fresh load sets lead, so the timed phase only sees the old effect
        if (lead_d != '0) begin
          lead_d = lead_d - 1'b1;
          on     = 1'b1;
        end else if (rem_q != '0) begin
          rem_d  = rem_q - 1'b1;
          astr_d = str_decayed;
          if (akind_q == KIND_SOLID) begin
            on = 1'b1;
          end else if (acc_q >= ACC_W'(ACC_THRESH)) begin
            acc_d = acc_q - ACC_W'(ACC_THRESH);
            on    = 1'b1;
          end else begin
            acc_d = acc_q + cube_add;
          end
        end else begin
          if (hold_q >= HOLD_W'(HOLD_ON_MIN)) begin
            on = 1'b1;
          end else if (hold_q >= HOLD_W'(HOLD_PULSE_MIN) && per_q != '0
                       && frame_rem == '0) begin
            on = 1'b1;
          end
        end
        if (hold_q != '0) begin
          hold_d = hold_q - 1'b1;
        end
        motor_d = on & enable_i;
      end
      MODE_QUEUE: begin
        if (enable_i) begin
          kind_d[LAST] = (str_q > STR_W'(SOLID_THRESH)) ? KIND_SOLID : KIND_DENSITY;
          sstr_d[LAST] = str_q;
          sdur_d[LAST] = dur_q;
          sdec_d[LAST] = '0;
        end
      end
      MODE_SET_DECAY: begin
        sdec_d[LAST] = dec_q;
      end
      MODE_RESET_HOLD: begin
        if (enable_i) begin
          hold_d = hold_rst;
          per_d  = PER_W'(PERIOD_RESTART);
        end
      end
      MODE_HOLD_LEVEL: begin
        if (enable_i) begin
          hold_d = hold_rst;
          if (lvl_q <= LVL_W'(LEVEL_MAX)) begin
            per_d = PER_W'(PERIOD_BASE) - PER_W'(lvl_q);
          end
        end
      end
      MODE_BUZZ: begin
        if (enable_i) begin
          hold_d = HOLD_W'(BUZZ_HOLD);
          per_d  = PER_W'(BUZZ_PERIOD);
        end
      end
      MODE_CANCEL: begin
        motor_d = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          kind_d[i] = KIND_NONE;
        end
        rem_d  = '0;
        hold_d = '0;
      end
      default: begin
        motor_d = motor_q;
      end
    endcase
  end

  always_comb begin
    any_slot = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (kind_d[i] != KIND_NONE) begin
        any_slot = 1'b1;
      end
    end
    busy_sum  = (DUR_W+1)'(lead_d) + (DUR_W+1)'(rem_d);
    idle_d    = (busy_sum < (DUR_W+1)'(LEAD_TICKS)) && !any_slot;
    changed_d = motor_d != motor_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        kind_q[i] <= KIND_NONE;
        sstr_q[i] <= '0;
        sdur_q[i] <= '0;
        sdec_q[i] <= '0;
      end
      akind_q     <= KIND_NONE;
      astr_q      <= '0;
      adec_q      <= '0;
      rem_q       <= '0;
      acc_q       <= '0;
      lead_q      <= '0;
      hold_q      <= '0;
      per_q       <= '0;
      motor_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        kind_q  <= kind_d;
        sstr_q  <= sstr_d;
        sdur_q  <= sdur_d;
        sdec_q  <= sdec_d;
        akind_q <= akind_d;
        astr_q  <= astr_d;
        adec_q  <= adec_d;
        rem_q   <= rem_d;
        acc_q   <= acc_d;
        lead_q  <= lead_d;
        hold_q  <= hold_d;
        per_q   <= per_d;
        motor_q <= motor_d;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_q   <= mode_e'(in_i.mode);
      dur_q <= in_i.duration;
      str_q <= in_i.strength;
      dec_q <= in_i.decay;
      lvl_q <= in_i.level;
    end
    if (cmd_i.commit) begin
      changed_q <= changed_d;
      idle_q    <= idle_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.motor_on      = motor_q;
  assign out_o.motor_changed = changed_q;
  assign out_o.idle          = idle_q;

  a_cancel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && m_q == MODE_CANCEL |=> !motor_q && rem_q == '0 && hold_q == '0)
    else $error("cancel left the motor or timers running");

  a_lead_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lead_q <= LEAD_W'(LEAD_TICKS))
    else $error("lead counter out of range");

  a_motor_only_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && m_q != MODE_TICK && m_q != MODE_CANCEL |=> $stable(motor_q))
    else $error("motor changed on a non-tick command");

endmodule

// ===== src/rumble_motor_pattern_controller.sv =====
// ----------------------------------------------------------------------------
// rumble_motor_pattern_controller - vibration motor pattern generator
// Queues rumble effects and decides the motor drive once per tick item.
//
//   channel  dir  handshake        payload
//   in_i     in   valid/ready      mode, duration, strength, decay, level,
//                                  frame_count
//   out_o    out  valid/ready      motor_on, motor_changed, idle
//   apb      in   psel/penable     rumble_enable at byte address 0
//
// One item is worked at a time. For a tick the controller waits in CALC while
// the frame counter is reduced modulo the pulse period one byte per cycle and
// the strength cube runs alongside; other commands go from IDLE to COMMIT.
// One result per item; the result register lets the next item in while a
// result waits, and a commit waits while the previous result is still held.
// Reset is asynchronous; latched item, result flags and math regs are not reset.
// ----------------------------------------------------------------------------
module rumble_motor_pattern_controller import rmpc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rmpc_in_if.sink           in_i,
  rmpc_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  rmpc_status_t st;
  rmpc_cmd_t    cmd;
  logic         enable_q;
  logic         sel_enable;

  assign sel_enable = (paddr[APB_AW-1:2] == REG_ENABLE_IDX);
  assign pready     = 1'b1;
  assign prdata     = sel_enable ? APB_DW'(enable_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= ENABLE_RST;
    end else if (psel && penable && pwrite && sel_enable) begin
      enable_q <= pwdata[0];
    end
  end

  rmpc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  rmpc_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .enable_i (enable_q),
    .in_i     (in_i),
    .out_o    (out_o),
    .cmd_i    (cmd),
    .st_o     (st)
  );

endmodule
